### rtl/core/packed_binary_field_decoder_defines.svh
// ---------------------------------------------------------------------------
// Packed binary field decoder assertion macros
// Shared property forms used by the decoder's port checker.
// ---------------------------------------------------------------------------
`ifndef PACKED_BINARY_FIELD_DECODER_DEFINES_SVH
`define PACKED_BINARY_FIELD_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PBFD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PBFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pbfd_pkg.sv
// ---------------------------------------------------------------------------
// Packed binary field decoder package
// Types, constants and arithmetic helpers shared by the decoder files.
// ---------------------------------------------------------------------------
package pbfd_pkg;

    localparam int MAX_BINARY_BYTES = 8;
    localparam int BIN_BITS         = 8 * MAX_BINARY_BYTES;

    localparam int VALUE_W     = 64;
    localparam int SCALE_W     = 5;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [63:0] I64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] I64_MIN_MAG = 64'h8000_0000_0000_0000;

    // Binary range limits, worked out from the binary byte count
    localparam logic [63:0] SBIN_LIM_POS = (64'd1 << (BIN_BITS - 1)) - 64'd1;
    localparam logic [63:0] SBIN_LIM_NEG = 64'd1 << (BIN_BITS - 1);
    localparam logic [63:0] UBIN_LIM_POS =
        (BIN_BITS < 64) ? ((64'd1 << BIN_BITS) - 64'd1) : I64_MAX;

    localparam logic [SCALE_W-1:0] SCALE_MAX = 5'd16;
    localparam logic [3:0]         CNT_MAX   = 4'd15;

    typedef enum logic [2:0] {
        MODE_DIGITS  = 3'd0,
        MODE_SPACKED = 3'd1,
        MODE_UPACKED = 3'd2,
        MODE_SBINARY = 3'd3,
        MODE_UBINARY = 3'd4,
        MODE_HEX     = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK  = 2'd0,
        ST_BAD = 2'd1,
        ST_OVF = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FORMAT_MODE = 2'd0,
        CFG_BIG_ENDIAN  = 2'd1,
        CFG_IMPLIED_DEC = 2'd2,
        CFG_DECIMALS    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MUL_10,
        MUL_100,
        MUL_16,
        MUL_256
    } mul_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic               big_endian;
        logic               idec_on;
        logic [SCALE_W-1:0] decimals;
    } cfg_t;

    typedef struct packed {
        logic [63:0] acc;
        logic [3:0]  cnt;
        logic        bad;
        logic        ovf;
        logic        hex_seen;
        logic        trail_seen;
        logic        sign;
        logic        ext_zero;
        logic        ext_ones;
    } field_state_t;

    localparam field_state_t FIELD_CLEAR = '{
        acc: 64'd0, cnt: 4'd0, bad: 1'b0, ovf: 1'b0, hex_seen: 1'b0,
        trail_seen: 1'b0, sign: 1'b0, ext_zero: 1'b1, ext_ones: 1'b1
    };

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [SCALE_W-1:0] scale;
        status_t            status;
    } result_t;

    typedef struct packed {
        logic [63:0] acc;
        logic        ovf;
    } mac_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] val;
    } hex_t;

    // acc * mul + add, saturating at all ones; multipliers are shift-adds
    function automatic mac_t mac(input logic [63:0] acc, input mul_t mul,
                                 input logic [7:0] add);
        logic [71:0] a;
        logic [71:0] p;
        mac_t        r;
        a = {8'd0, acc};
        unique case (mul)
            MUL_10:  p = (a << 3) + (a << 1);
            MUL_100: p = (a << 6) + (a << 5) + (a << 2);
            MUL_16:  p = a << 4;
            MUL_256: p = a << 8;
        endcase
        p = p + {64'd0, add};
        r.ovf = |p[71:64];
        r.acc = r.ovf ? '1 : p[63:0];
        return r;
    endfunction

    function automatic hex_t hex_value(input logic [7:0] b);
        hex_t r;
        r.valid = 1'b1;
        r.val   = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r.val = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66) begin
            r.val = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46) begin
            r.val = 4'(b - 8'h37);
        end
        else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    // Mask of the low n bytes, n in 1..8
    function automatic logic [63:0] low_mask(input logic [3:0] n);
        logic [63:0] m;
        unique case (n)
            4'd1:    m = 64'h0000_0000_0000_00FF;
            4'd2:    m = 64'h0000_0000_0000_FFFF;
            4'd3:    m = 64'h0000_0000_00FF_FFFF;
            4'd4:    m = 64'h0000_0000_FFFF_FFFF;
            4'd5:    m = 64'h0000_00FF_FFFF_FFFF;
            4'd6:    m = 64'h0000_FFFF_FFFF_FFFF;
            4'd7:    m = 64'h00FF_FFFF_FFFF_FFFF;
            default: m = '1;
        endcase
        return m;
    endfunction

    // Top bit of the low n bytes, n in 1..8
    function automatic logic top_bit_of(input logic [63:0] v, input logic [3:0] n);
        logic [6:0] span;
        logic [5:0] idx;
        span = {n, 3'b000};
        idx  = 6'(span - 7'd1);
        return v[idx];
    endfunction

endpackage

### rtl/core/pbfd_if.sv
// ---------------------------------------------------------------------------
// Packed binary field decoder channels
// Byte input, result output and configuration write channels.
// ---------------------------------------------------------------------------
interface pbfd_byte_if import pbfd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pbfd_result_if import pbfd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic [SCALE_W-1:0]        decimal_scale;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, output value, output decimal_scale, output status,
                    input ready);
    modport sink   (input valid, input value, input decimal_scale, input status,
                    output ready);
endinterface

interface pbfd_cfg_if import pbfd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

### rtl/core/pbfd_field_logic.sv
// ---------------------------------------------------------------------------
// Packed binary field decoder byte logic
// Next field state for one byte, and the finished result on the last byte.
// ---------------------------------------------------------------------------
module pbfd_field_logic import pbfd_pkg::*;
(
    input  cfg_t         cfg,
    input  field_state_t cur,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    output field_state_t nxt,
    output result_t      res
);

    mul_t        mac_mul;
    logic [7:0]  mac_add;
    logic        mac_en;
    mac_t        mr;
    hex_t        hv;
    logic        b_space;
    logic        b_digit;
    logic        sign_now;
    logic [7:0]  packed_pair;
    logic        neg_packed;

    logic        exceed;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] lim_pos;
    logic [63:0] lim_neg;
    logic [63:0] lim;
    logic [3:0]  n;
    logic        n_fits;

    assign hv          = hex_value(data_byte);
    assign b_space     = is_space(data_byte);
    assign b_digit     = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    assign sign_now    = (cur.cnt == 4'd0) ? data_byte[7] : cur.sign;
    assign packed_pair = ({4'd0, data_byte[7:4]} << 3) + ({4'd0, data_byte[7:4]} << 1)
                         + {4'd0, data_byte[3:0]};
    assign neg_packed  = data_byte[4] ^ data_byte[5];

    // Pick the single multiply-add for this byte
    always_comb
    begin
        mac_mul = MUL_10;
        mac_add = 8'd0;
        mac_en  = 1'b0;
        unique case (cfg.mode)
            MODE_DIGITS:
            begin
                mac_en  = b_digit;
                mac_add = data_byte - 8'h30;
            end
            MODE_SPACKED:
            begin
                mac_en = 1'b1;
                if (last_byte)
                begin
                    mac_add = {4'd0, data_byte[7:4]};
                end
                else
                begin
                    mac_mul = MUL_100;
                    mac_add = packed_pair;
                end
            end
            MODE_UPACKED:
            begin
                mac_en  = 1'b1;
                mac_mul = MUL_100;
                mac_add = packed_pair;
            end
            MODE_SBINARY, MODE_UBINARY:
            begin
                mac_en  = cfg.big_endian;
                mac_mul = MUL_256;
                mac_add = (cfg.mode == MODE_SBINARY && sign_now) ? ~data_byte : data_byte;
            end
            MODE_HEX:
            begin
                mac_en  = !b_space && hv.valid && !cur.trail_seen;
                mac_mul = MUL_16;
                mac_add = {4'd0, hv.val};
            end
            default:
            begin
                mac_en = 1'b0;
            end
        endcase
    end

    assign mr = mac(cur.acc, mac_mul, mac_add);

    // Field state after this byte
    always_comb
    begin
        nxt = cur;
        if (mac_en)
        begin
            nxt.acc = mr.acc;
            nxt.ovf = cur.ovf | mr.ovf;
        end
        unique case (cfg.mode)
            MODE_DIGITS:
            begin
                if (!b_digit)
                begin
                    nxt.bad = 1'b1;
                end
            end
            MODE_SPACKED, MODE_UPACKED:
            begin
                nxt.bad = cur.bad;
            end
            MODE_SBINARY, MODE_UBINARY:
            begin
                if (cfg.big_endian)
                begin
                    if (cfg.mode == MODE_SBINARY)
                    begin
                        nxt.sign = sign_now;
                    end
                end
                else if (!cur.cnt[3])
                begin
                    nxt.acc = cur.acc | ({56'd0, data_byte} << {cur.cnt[2:0], 3'b000});
                end
                else
                begin
                    // bytes past the eighth only extend the value
                    if (data_byte != 8'h00)
                    begin
                        nxt.ext_zero = 1'b0;
                    end
                    if (data_byte != 8'hFF)
                    begin
                        nxt.ext_ones = 1'b0;
                    end
                    if (cfg.mode == MODE_UBINARY && data_byte != 8'h00)
                    begin
                        nxt.ovf = 1'b1;
                    end
                    nxt.sign = data_byte[7];
                end
            end
            MODE_HEX:
            begin
                if (b_space)
                begin
                    if (cur.hex_seen)
                    begin
                        nxt.trail_seen = 1'b1;
                    end
                end
                else if (hv.valid && !cur.trail_seen)
                begin
                    nxt.hex_seen = 1'b1;
                end
                else
                begin
                    nxt.bad = 1'b1;
                end
            end
            default:
            begin
                nxt.bad = 1'b1;
            end
        endcase
        if (cur.cnt != CNT_MAX)
        begin
            nxt.cnt = cur.cnt + 4'd1;
        end
    end

    // Sign, range and saturation of the finished field
    always_comb
    begin
        exceed  = nxt.ovf;
        mag     = nxt.acc;
        neg     = 1'b0;
        lim_pos = I64_MAX;
        lim_neg = I64_MIN_MAG;
        n       = nxt.cnt;
        n_fits  = 1'b1;
        unique case (cfg.mode)
            MODE_SPACKED:
            begin
                neg = neg_packed;
            end
            MODE_SBINARY:
            begin
                lim_pos = SBIN_LIM_POS;
                lim_neg = SBIN_LIM_NEG;
                if (cfg.big_endian)
                begin
                    // magnitude of a negative value was built from inverted bytes
                    neg = nxt.sign;
                    if (neg)
                    begin
                        if (&nxt.acc)
                        begin
                            exceed = 1'b1;
                        end
                        else
                        begin
                            mag = nxt.acc + 64'd1;
                        end
                    end
                end
                else
                begin
                    if (n > 4'd8)
                    begin
                        if ((nxt.ext_zero && !nxt.acc[63]) || (nxt.ext_ones && nxt.acc[63]))
                        begin
                            n = 4'd8;
                        end
                        else
                        begin
                            exceed = 1'b1;
                            neg    = nxt.sign;
                            n_fits = 1'b0;
                        end
                    end
                    if (n_fits)
                    begin
                        neg = top_bit_of(nxt.acc, n);
                        if (neg)
                        begin
                            mag = (~nxt.acc + 64'd1) & low_mask(n);
                        end
                    end
                end
            end
            MODE_UBINARY:
            begin
                lim_pos = UBIN_LIM_POS;
            end
            default:
            begin
                neg = 1'b0;
            end
        endcase

        lim = neg ? lim_neg : lim_pos;
        if (nxt.bad)
        begin
            res.value  = '0;
            res.scale  = '0;
            res.status = ST_BAD;
        end
        else
        begin
            res.status = ST_OK;
            if (exceed || mag > lim)
            begin
                mag        = lim;
                res.status = ST_OVF;
            end
            res.value = neg ? (64'd0 - mag) : mag;
            res.scale = '0;
            if (cfg.idec_on && cfg.mode <= MODE_UBINARY)
            begin
                res.scale = (cfg.decimals > SCALE_MAX) ? SCALE_MAX : cfg.decimals;
            end
        end
    end

endmodule

### rtl/core/packed_binary_field_decoder.sv
// ---------------------------------------------------------------------------
// Packed binary field decoder
// Decodes one field per run of bytes into a saturated signed 64-bit value.
// ---------------------------------------------------------------------------
//  channel       dir  carries                                  transaction
//  field_bytes   in   data_byte, last_byte                     valid & ready
//  results       out  value, decimal_scale, status             valid & ready
//  cfg           in   index, wdata (always ready)              valid & ready
//
//  One byte per cycle while no result stalls; each result is registered.
//  The rate is set by the accumulator update: one constant multiply-add
//  with saturation per byte, between the byte register and the state.
//  Reset clears the configuration, the field state and both valid flags.
//  A stalled result holds the last byte in the byte register, and the
//  byte input stalls behind it until the result is taken.
// ---------------------------------------------------------------------------
module packed_binary_field_decoder import pbfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    pbfd_byte_if.sink            field_bytes,
    pbfd_result_if.source        results,
    pbfd_cfg_if.sink             cfg
);

    cfg_t         cfg_reg;
    cfg_t         cfg_next;
    field_state_t field_reg;
    field_state_t field_next;
    field_state_t field_upd;
    result_t      res_comb;

    logic         s1_valid_reg;
    logic         s1_valid_next;
    logic [7:0]   s1_byte_reg;
    logic         s1_last_reg;

    logic         out_valid_reg;
    logic         out_valid_next;
    result_t      out_res_reg;

    logic         in_xfer;
    logic         cfg_xfer;
    logic         res_free;
    logic         s1_advance;
    logic         s1_finish;

    assign cfg.ready   = 1'b1;
    assign cfg_xfer    = cfg.valid & cfg.ready;

    assign res_free    = !out_valid_reg || results.ready;
    assign s1_advance  = s1_valid_reg && (!s1_last_reg || res_free);
    assign s1_finish   = s1_advance && s1_last_reg;

    assign field_bytes.ready = !s1_valid_reg || s1_advance;
    assign in_xfer           = field_bytes.valid & field_bytes.ready;

    pbfd_field_logic u_field_logic (
        .cfg       (cfg_reg),
        .cur       (field_reg),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .nxt       (field_upd),
        .res       (res_comb)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_xfer)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_FORMAT_MODE: cfg_next.mode       = cfg.wdata[2:0];
                CFG_BIG_ENDIAN:  cfg_next.big_endian = cfg.wdata[0];
                CFG_IMPLIED_DEC: cfg_next.idec_on    = cfg.wdata[0];
                CFG_DECIMALS:    cfg_next.decimals   = cfg.wdata;
            endcase
        end
    end

    // Drop the field on a register write or once its last byte is decoded
    always_comb
    begin
        field_next = field_reg;
        if (cfg_xfer || s1_finish)
        begin
            field_next = FIELD_CLEAR;
        end
        else if (s1_advance)
        begin
            field_next = field_upd;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            field_reg     <= FIELD_CLEAR;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            field_reg     <= field_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_byte_reg <= field_bytes.data_byte;
            s1_last_reg <= field_bytes.last_byte;
        end
        if (s1_finish)
        begin
            out_res_reg <= res_comb;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.value         = $signed(out_res_reg.value);
    assign results.decimal_scale = out_res_reg.scale;
    assign results.status        = out_res_reg.status;

endmodule

### rtl/core/pbfd_checker.sv
// ---------------------------------------------------------------------------
// Packed binary field decoder port checker
// Properties of the decoder seen at its ports, bound to the top level.
// ---------------------------------------------------------------------------
`include "packed_binary_field_decoder_defines.svh"

module pbfd_checker import pbfd_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      in_last,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [VALUE_W-1:0] out_value,
    input logic [SCALE_W-1:0]        out_scale,
    input logic [STATUS_W-1:0]       out_status
);

    // A bad field reports a zero value with no scale
    `PBFD_ASSERT_SAME(a_bad_is_zero, out_valid && out_status == ST_BAD, out_value == 0 && out_scale == '0, "bad field with nonzero value or scale")

    `PBFD_ASSERT_SAME(a_scale_range, out_valid, out_scale <= SCALE_MAX, "decimal scale above limit")

    // With the result side open behind it, an accepted last byte yields a valid result
    `PBFD_ASSERT_NEXT(a_last_answered, (in_valid && in_ready && in_last) ##1 out_ready, out_valid, "last byte produced no result")

    `PBFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_status) && $stable(out_scale), "stalled result changed")

endmodule

bind packed_binary_field_decoder pbfd_checker u_pbfd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (field_bytes.valid),
    .in_ready   (field_bytes.ready),
    .in_last    (field_bytes.last_byte),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_value  (results.value),
    .out_scale  (results.decimal_scale),
    .out_status (results.status)
);
